/* src/wwm_pkg.sv */
// shared types, constants and functions of the wildcard word matcher
package wwm_pkg;

  localparam int NUM_PATTERNS = 4;
  localparam int PATTERN_LEN  = 32;
  localparam int VEC_W        = PATTERN_LEN + 1;
  localparam int SEL_W        = 2;
  localparam int IDX_W        = 6;
  localparam int POS_W        = $clog2(PATTERN_LEN);
  localparam int LINE_W       = 24;
  localparam int CNT_W        = 16;
  localparam int ACT_W        = 3;
  localparam int CFG_DATA_W   = 3;

  localparam logic [1:0] CMD_TEXT = 2'd0;
  localparam logic [1:0] CMD_EOS  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_SINGLE  = 2'd1;
  localparam logic [1:0] KIND_RUN     = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic CFG_FOLD_CASE = 1'b0;
  localparam logic CFG_ACTIVE    = 1'b1;

  // classified request kinds passed from front to back
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_BYTE    = 3'd1,
    OP_SPACE   = 3'd2,
    OP_NEWLINE = 3'd3,
    OP_EOS     = 3'd4,
    OP_ELEM    = 3'd5,
    OP_LEN     = 3'd6
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic [1:0]       kind;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } elem_t;

  // lower-case an upper-case letter
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) r = c + 8'd32;
    return r;
  endfunction

  // follow any-run elements forward, parallel prefix over the vector
  function automatic logic [VEC_W-1:0] run_close(input logic [VEC_W-1:0] v,
                                                 input logic [PATTERN_LEN-1:0] run);
    logic [VEC_W-1:0] g;
    logic [VEC_W-1:0] p;
    logic [VEC_W-1:0] gn;
    logic [VEC_W-1:0] pn;
    g = v;
    p = {run, 1'b0};
    for (int s = 1; s < VEC_W; s = s * 2) begin
      gn = g;
      pn = '0;
      for (int j = s; j < VEC_W; j++) begin
        gn[j] = g[j] | (p[j] & g[j-s]);
        pn[j] = p[j] & p[j-s];
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

endpackage

/* src/wildcard_word_matcher.sv */
// top level of the wildcard word matcher
// Usage: requests arrive on the in_ channel (valid/ready). cmd 0 carries a
// text byte, cmd 1 marks end of stream, cmd 2 loads one pattern element
// (literal, any single, any run, or end, which sets the pattern length).
// Words split at space, tab and newline; each word is searched against the
// active patterns with an implied leading any-run.
// When a word closes and an active pattern matched, one result leaves on the
// out_ channel with line, start column, length and lowest matching pattern.
// Throughput: one request per cycle while the receiver does not stall. A
// request is registered in a two-entry queue and handled by the back end
// from there; the result is loaded into the output register when the back
// end takes the closing request. The per-byte automaton step updates all
// element positions of all patterns in parallel.
// If the receiver stalls, the result register holds and the back end stops;
// the queue then fills and in_ready falls once two requests wait in it.
// Reset (rst_n low at a clock edge) empties the queue, sets line and column
// to 1, pattern lengths to 0, case folding off and the active count to 1.
// Pattern element contents are undefined until loaded.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
module wildcard_word_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [wwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [7:0]                    in_data_byte,
  input  logic [1:0]                    in_pattern_select,
  input  logic [5:0]                    in_element_index,
  input  logic [1:0]                    in_element_kind,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [23:0]                   out_line_number,
  output logic [15:0]                   out_start_column,
  output logic [15:0]                   out_word_length,
  output logic [1:0]                    out_pattern_hit
);
  import wwm_pkg::*;

  item_t q_item;
  logic  q_valid, q_ready;

  // front end with request queue
  wwm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_data_byte,
    .in_pattern_select, .in_element_index, .in_element_kind,
    .q_valid, .q_ready, .q_item
  );

  // back end with automaton and result register
  wwm_back u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_line_number, .out_start_column,
    .out_word_length, .out_pattern_hit
  );

endmodule

/* src/wwm_front.sv */
// front end: classifies requests and queues them for the back end
module wwm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_data_byte,
  input  logic [1:0]           in_pattern_select,
  input  logic [5:0]           in_element_index,
  input  logic [1:0]           in_element_kind,
  output logic                 q_valid,
  input  logic                 q_ready,
  output wwm_pkg::item_t       q_item
);
  import wwm_pkg::*;

  item_t      cls;
  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // classify the incoming request
  always_comb begin
    cls.data = in_data_byte;
    cls.sel  = in_pattern_select;
    cls.idx  = in_element_index;
    cls.kind = in_element_kind;
    cls.op   = OP_NOP;
    case (in_cmd)
      CMD_TEXT: begin
        if (in_data_byte == CH_NEWLINE) cls.op = OP_NEWLINE;
        else if (in_data_byte inside {CH_SPACE, CH_TAB}) cls.op = OP_SPACE;
        else cls.op = OP_BYTE;
      end
      CMD_EOS: cls.op = OP_EOS;
      CMD_LOAD: begin
        if (32'(in_pattern_select) < NUM_PATTERNS) begin
          if (in_element_kind == KIND_END) begin
            if (32'(in_element_index) <= PATTERN_LEN) cls.op = OP_LEN;
          end else if (32'(in_element_index) < PATTERN_LEN) begin
            cls.op = OP_ELEM;
          end
        end
      end
      default: cls.op = OP_NOP;
    endcase
  end

  // two-entry queue
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= cls;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("full queue lost an entry");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("pointers disagree with count");

endmodule

/* src/wwm_back.sv */
// back end: counters, glob automaton and result register
module wwm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [wwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  wwm_pkg::item_t                q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [23:0]                   out_line_number,
  output logic [15:0]                   out_start_column,
  output logic [15:0]                   out_word_length,
  output logic [1:0]                    out_pattern_hit
);
  import wwm_pkg::*;

  logic                   icase_r;
  logic [ACT_W-1:0]       active_r;
  elem_t                  store_r [NUM_PATTERNS][PATTERN_LEN];
  logic [IDX_W-1:0]       plen_r  [NUM_PATTERNS];
  logic [VEC_W-1:0]       mv_r    [NUM_PATTERNS];
  logic [VEC_W-1:0]       mv_nxt  [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0] hits_r, hits_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [CNT_W-1:0]       wstart_r, wstart_nxt;
  logic [CNT_W-1:0]       wlen_r, wlen_nxt;
  logic                   inside_r, inside_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0]      out_line_r;
  logic [CNT_W-1:0]       out_col_r, out_len_r;
  logic [SEL_W-1:0]       out_hit_r, hit_sel;
  logic                   take, result, any_hit, word_end;
  logic [NUM_PATTERNS-1:0] hit_mask;

  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icase_r  <= 1'b0;
      active_r <= ACT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FOLD_CASE: icase_r  <= cfg_wdata[0];
        CFG_ACTIVE:    active_r <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-pattern automaton step, one lane per pattern
  always_comb begin
    logic [PATTERN_LEN-1:0] run;
    logic [VEC_W-1:0]       base, nv, cl;
    logic                   act;
    logic                   hb;
    hits_nxt = hits_r;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      mv_nxt[p] = mv_r[p];
      for (int i = 0; i < PATTERN_LEN; i++)
        run[i] = (store_r[p][i].kind == KIND_RUN) && (i < 32'(plen_r[p]));
      if (inside_r) begin
        base = mv_r[p];
        hb   = hits_r[p];
      end else begin
        base = run_close(VEC_W'(1), run);
        hb   = base[plen_r[p]];
      end
      nv = '0;
      nv[0] = 1'b1;
      for (int i = 0; i < PATTERN_LEN; i++) begin
        act = base[i] && (i < 32'(plen_r[p]));
        if (act && store_r[p][i].kind == KIND_RUN) nv[i] = 1'b1;
        if (act && store_r[p][i].kind == KIND_SINGLE) nv[i+1] = 1'b1;
        if (act && store_r[p][i].kind == KIND_LITERAL &&
            (store_r[p][i].ch == q_item.data ||
             (icase_r && fold(store_r[p][i].ch) == fold(q_item.data))))
          nv[i+1] = 1'b1;
      end
      cl = run_close(nv, run);
      if (take && q_item.op == OP_BYTE) begin
        mv_nxt[p]   = cl;
        hits_nxt[p] = hb | cl[plen_r[p]];
      end
    end
  end

  // pick the lowest active pattern that hit
  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++)
      hit_mask[p] = hits_r[p] && (p < 32'(active_r));
    any_hit = |hit_mask;
    hit_sel = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--)
      if (hit_mask[p]) hit_sel = SEL_W'(p);
  end

  // counters and word tracking
  always_comb begin
    line_nxt   = line_r;
    col_nxt    = col_r;
    wstart_nxt = wstart_r;
    wlen_nxt   = wlen_r;
    inside_nxt = inside_r;
    word_end   = 1'b0;
    if (take) begin
      case (q_item.op)
        OP_BYTE: begin
          inside_nxt = 1'b1;
          if (!inside_r) begin
            wstart_nxt = col_r;
            wlen_nxt   = CNT_W'(1);
          end else if (wlen_r != '1) begin
            wlen_nxt = wlen_r + 1'b1;
          end
          if (col_r != '1) col_nxt = col_r + 1'b1;
        end
        OP_SPACE: begin
          word_end   = inside_r;
          inside_nxt = 1'b0;
          if (col_r != '1) col_nxt = col_r + 1'b1;
        end
        OP_NEWLINE: begin
          word_end   = inside_r;
          inside_nxt = 1'b0;
          if (line_r != '1) line_nxt = line_r + 1'b1;
          col_nxt = CNT_W'(1);
        end
        OP_EOS: begin
          word_end   = inside_r;
          inside_nxt = 1'b0;
          line_nxt   = LINE_W'(1);
          col_nxt    = CNT_W'(1);
        end
        default: ;
      endcase
    end
    result        = word_end && any_hit;
    out_valid_nxt = result ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= LINE_W'(1);
      col_r       <= CNT_W'(1);
      wstart_r    <= '0;
      wlen_r      <= '0;
      inside_r    <= 1'b0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        plen_r[p] <= '0;
        mv_r[p]   <= '0;
      end
    end else begin
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      wstart_r    <= wstart_nxt;
      wlen_r      <= wlen_nxt;
      inside_r    <= inside_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
      for (int p = 0; p < NUM_PATTERNS; p++) mv_r[p] <= mv_nxt[p];
      if (take && q_item.op == OP_LEN) plen_r[q_item.sel] <= q_item.idx;
    end
  end

  // pattern element store and result payload
  always_ff @(posedge clk) begin
    if (take && q_item.op == OP_ELEM)
      store_r[q_item.sel][q_item.idx[POS_W-1:0]] <= '{kind: q_item.kind, ch: q_item.data};
    if (result) begin
      out_line_r <= line_r;
      out_col_r  <= wstart_r;
      out_len_r  <= wlen_r;
      out_hit_r  <= hit_sel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_number  = out_line_r;
  assign out_start_column = out_col_r;
  assign out_word_length  = out_len_r;
  assign out_pattern_hit  = out_hit_r;

  a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> wlen_r != '0) else $error("open word with zero length");
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0 && col_r != '0) else $error("line or column counter at zero");
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    result |=> out_valid_r && out_word_length != '0 && out_start_column != '0)
    else $error("result register loaded with empty word");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !take) else $error("request taken while result stalled");

endmodule
